// ===== rtl/psg_tone_noise_mixer_assert.svh =====
// Assertion macros used by the sound generator controller.
`ifndef PSG_TONE_NOISE_MIXER_ASSERT_SVH
`define PSG_TONE_NOISE_MIXER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define PSG_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PSG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/psg_pkg.sv =====
// Types, constants and tables shared by the sound generator modules.
package psg_pkg;

    // request command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // configuration register indexes
    localparam logic CFG_CHIP_CLOCK  = 1'b0;
    localparam logic CFG_SAMPLE_RATE = 1'b1;

    localparam logic [21:0] CHIP_CLOCK_RST  = 22'd1000000;
    localparam logic [17:0] SAMPLE_RATE_RST = 18'd44100;

    // sound register addresses
    localparam logic [3:0] REG_TONE_A_LO = 4'd0;
    localparam logic [3:0] REG_TONE_A_HI = 4'd1;
    localparam logic [3:0] REG_TONE_B_LO = 4'd2;
    localparam logic [3:0] REG_TONE_B_HI = 4'd3;
    localparam logic [3:0] REG_TONE_C_LO = 4'd4;
    localparam logic [3:0] REG_TONE_C_HI = 4'd5;
    localparam logic [3:0] REG_NOISE     = 4'd6;
    localparam logic [3:0] REG_MIXER     = 4'd7;
    localparam logic [3:0] REG_VOL_A     = 4'd8;
    localparam logic [3:0] REG_VOL_B     = 4'd9;
    localparam logic [3:0] REG_VOL_C     = 4'd10;

    localparam int DIV_DEND_W = 24;
    localparam int DIV_DSOR_W = 18;
    localparam int DIV_STEPS  = DIV_DEND_W / 2;

    localparam int LFSR_W = 17;
    localparam logic [LFSR_W-1:0] NOISE_CYCLE = 17'd131071;
    localparam logic [4:0] JUMP_LAST = 5'(LFSR_W - 1);

    localparam logic signed [17:0] CLAMP_HI = 18'sd32000;
    localparam logic signed [17:0] CLAMP_LO = -18'sd32000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LAUNCH,
        S_DIV,
        S_JUMP,
        S_MIX,
        S_FILT
    } t_state;

    typedef enum logic [2:0] {
        JOB_RATE,
        JOB_TONE_A,
        JOB_TONE_B,
        JOB_TONE_C,
        JOB_NOISE
    } t_job;

    typedef struct packed {
        logic       wr_reg;
        logic       div_start;
        logic       commit;
        t_job       job;
        logic       jump;
        logic [4:0] jump_bit;
        logic       mix;
        logic       filt;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_dp_stat;

    // row r of a matrix says which old bits XOR into new bit r
    typedef logic [LFSR_W-1:0][LFSR_W-1:0] t_lfsr_mat;
    typedef t_lfsr_mat [LFSR_W-1:0] t_lfsr_tab;

    // Jump matrices for 1, 2, 4, ... 2^16 noise shifts, by repeated squaring.
    function automatic t_lfsr_tab lfsr_jump_tab();
        t_lfsr_tab tab;
        t_lfsr_mat m;
        t_lfsr_mat sq;
        int i;
        int r;
        int c;
        int k;
        m = '0;
        for (r = 0; r < LFSR_W - 1; r++) begin
            m[r][r+1] = 1'b1;
        end
        m[LFSR_W-1][0] = 1'b1;
        m[LFSR_W-1][3] = 1'b1;
        for (i = 0; i < LFSR_W; i++) begin
            tab[i] = m;
            sq = '0;
            for (r = 0; r < LFSR_W; r++) begin
                for (c = 0; c < LFSR_W; c++) begin
                    for (k = 0; k < LFSR_W; k++) begin
                        sq[r][c] = sq[r][c] ^ (m[r][k] & m[k][c]);
                    end
                end
            end
            m = sq;
        end
        return tab;
    endfunction

    // logarithmic volume ladder
    function automatic logic [11:0] vol_level(input logic [3:0] v);
        logic [11:0] lvl;
        unique case (v)
            4'd0:    lvl = 12'd0;
            4'd1:    lvl = 12'd23;
            4'd2:    lvl = 12'd33;
            4'd3:    lvl = 12'd47;
            4'd4:    lvl = 12'd67;
            4'd5:    lvl = 12'd95;
            4'd6:    lvl = 12'd135;
            4'd7:    lvl = 12'd191;
            4'd8:    lvl = 12'd270;
            4'd9:    lvl = 12'd382;
            4'd10:   lvl = 12'd541;
            4'd11:   lvl = 12'd766;
            4'd12:   lvl = 12'd1084;
            4'd13:   lvl = 12'd1534;
            4'd14:   lvl = 12'd2171;
            default: lvl = 12'd3072;
        endcase
        return lvl;
    endfunction

endpackage

// ===== rtl/psg_if.sv =====
// Request, result and configuration channel interfaces of the sound generator.
interface psg_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [3:0] reg_addr;
    logic [7:0] reg_value;

    modport source (output valid, cmd, reg_addr, reg_value, input ready);
    modport sink (input valid, cmd, reg_addr, reg_value, output ready);
endinterface

interface psg_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;

    modport source (output valid, sample, input ready);
    modport sink (input valid, sample, output ready);
endinterface

interface psg_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [21:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/psg_div.sv =====
// Restoring divider, two quotient bits per cycle.
module psg_div
    import psg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIV_DEND_W-1:0] i_dividend,
    input  logic [DIV_DSOR_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [DIV_DEND_W-1:0] o_quot,
    output logic [DIV_DSOR_W-1:0] o_rem
);

    localparam logic [3:0] LastStep = 4'(DIV_STEPS - 1);

    logic                  r_busy;
    logic                  r_done;
    logic [3:0]            r_cnt;
    logic [DIV_DSOR_W-1:0] r_rem;
    logic [DIV_DSOR_W-1:0] r_dsor;
    logic [DIV_DEND_W-1:0] r_quot;

    logic [DIV_DSOR_W:0]   t1;
    logic [DIV_DSOR_W:0]   t2;
    logic                  ge1;
    logic                  ge2;
    logic [DIV_DSOR_W-1:0] rem1;
    logic [DIV_DSOR_W-1:0] n_rem;
    logic [DIV_DEND_W-1:0] n_quot;

    always_comb begin
        t1     = {r_rem, r_quot[DIV_DEND_W-1]};
        ge1    = t1 >= {1'b0, r_dsor};
        rem1   = ge1 ? DIV_DSOR_W'(t1 - {1'b0, r_dsor}) : t1[DIV_DSOR_W-1:0];
        t2     = {rem1, r_quot[DIV_DEND_W-2]};
        ge2    = t2 >= {1'b0, r_dsor};
        n_rem  = ge2 ? DIV_DSOR_W'(t2 - {1'b0, r_dsor}) : t2[DIV_DSOR_W-1:0];
        n_quot = {r_quot[DIV_DEND_W-3:0], ge1, ge2};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 4'd1;
            if (r_cnt == LastStep) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
            r_dsor <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= n_quot;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/psg_dp.sv =====
// Datapath: sound registers, generators, noise jump, mixer, filter and result register.
module psg_dp
    import psg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    output t_dp_stat   o_stat,
    input  logic [3:0] i_reg_addr,
    input  logic [7:0] i_reg_value,
    psg_cfg_if.sink    i_cfg,
    psg_out_if.source  o_res
);

    localparam t_lfsr_tab LfsrJump = lfsr_jump_tab();

    logic [21:0]       r_chip_clock;
    logic [17:0]       r_sample_rate;
    logic [11:0]       r_tone_period [3];
    logic [3:0]        r_tone_vol [3];
    logic [14:0]       r_tone_count [3];
    logic [2:0]        r_tone_level;
    logic [4:0]        r_noise_period;
    logic [7:0]        r_noise_count;
    logic [LFSR_W-1:0] r_noise;
    logic [5:0]        r_mixer;
    logic [17:0]       r_frac;
    logic [22:0]       r_cycles;
    logic [LFSR_W-1:0] r_shifts;
    logic [14:0]       r_x;
    logic [14:0]       r_hp_prev;
    logic [15:0]       r_hp;
    logic              r_out_valid;
    logic [15:0]       r_out_sample;

    logic [DIV_DEND_W-1:0] div_dend;
    logic [DIV_DSOR_W-1:0] div_dsor;
    logic                  div_done;
    logic [DIV_DEND_W-1:0] div_quot;
    logic [DIV_DSOR_W-1:0] div_rem;

    logic [1:0]        job_ch;
    logic [11:0]       tone_p;
    logic [4:0]        noise_p;
    logic [17:0]       rate;
    logic [18:0]       frac_sum;
    logic [17:0]       fold;
    logic [LFSR_W-1:0] n_noise_jmp;
    logic [13:0]       mix;
    logic              tone_off;
    logic              noise_off;
    logic              chan_on;
    logic [25:0]       hp_prod;
    logic [25:0]       hp_adj;
    logic [15:0]       hp_decay;
    logic signed [17:0] y;
    logic signed [17:0] y_clamp;

    psg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dend),
        .i_divisor  (div_dsor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // divider operands for the current job
    always_comb begin
        unique case (i_cmd.job)
            JOB_TONE_A: job_ch = 2'd0;
            JOB_TONE_B: job_ch = 2'd1;
            JOB_TONE_C: job_ch = 2'd2;
            default:    job_ch = 2'd0;
        endcase
        tone_p  = (r_tone_period[job_ch] == '0) ? 12'd1 : r_tone_period[job_ch];
        noise_p = (r_noise_period == '0) ? 5'd1 : r_noise_period;
        rate    = (r_sample_rate == '0) ? 18'd1 : r_sample_rate;
        unique case (i_cmd.job)
            JOB_RATE: begin
                div_dend = {2'b0, r_chip_clock};
                div_dsor = rate;
            end
            JOB_NOISE: begin
                div_dend = {16'b0, r_noise_count} + {1'b0, r_cycles};
                div_dsor = {10'b0, noise_p, 3'b0};
            end
            default: begin
                div_dend = {9'b0, r_tone_count[job_ch]} + {1'b0, r_cycles};
                div_dsor = {3'b0, tone_p, 3'b0};
            end
        endcase
        frac_sum = {1'b0, r_frac} + {1'b0, div_rem};
        // shift count modulo the register cycle: fold the high bits back in
        fold = {1'b0, div_quot[LFSR_W-1:0]} + {11'b0, div_quot[DIV_DEND_W-1:LFSR_W]};
        if (fold >= {1'b0, NOISE_CYCLE}) begin
            fold = fold - {1'b0, NOISE_CYCLE};
        end
    end

    always_comb begin
        for (int r = 0; r < LFSR_W; r++) begin
            n_noise_jmp[r] = ^(LfsrJump[i_cmd.jump_bit][r] & r_noise);
        end
    end

    always_comb begin
        mix = '0;
        tone_off  = 1'b0;
        noise_off = 1'b0;
        chan_on   = 1'b0;
        for (int ch = 0; ch < 3; ch++) begin
            tone_off  = r_mixer[ch];
            noise_off = r_mixer[ch+3];
            chan_on   = (tone_off | r_tone_level[ch]) & (noise_off | r_noise[0]);
            if (!(tone_off && noise_off) && chan_on) begin
                mix = mix + {2'b0, vol_level(r_tone_vol[ch])};
            end
        end
    end

    // decay term hp * 1023 / 1024, truncated toward zero
    always_comb begin
        hp_prod  = {r_hp, 10'b0} - {{10{r_hp[15]}}, r_hp};
        hp_adj   = hp_prod[25] ? hp_prod + 26'd1023 : hp_prod;
        hp_decay = hp_adj[25:10];
        y = $signed({3'b0, r_x} - {3'b0, r_hp_prev} + {{2{hp_decay[15]}}, hp_decay});
        if (y > CLAMP_HI) begin
            y_clamp = CLAMP_HI;
        end else if (y < CLAMP_LO) begin
            y_clamp = CLAMP_LO;
        end else begin
            y_clamp = y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chip_clock  <= CHIP_CLOCK_RST;
            r_sample_rate <= SAMPLE_RATE_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_CHIP_CLOCK:  r_chip_clock  <= i_cfg.data;
                CFG_SAMPLE_RATE: r_sample_rate <= i_cfg.data[17:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_tone_period[ch] <= 12'd1;
                r_tone_vol[ch]    <= '0;
                r_tone_count[ch]  <= '0;
            end
            r_tone_level   <= '0;
            r_noise_period <= 5'd1;
            r_noise_count  <= '0;
            r_noise        <= 17'd1;
            r_mixer        <= 6'h3f;
            r_frac         <= '0;
            r_hp           <= '0;
            r_hp_prev      <= '0;
        end else begin
            if (i_cmd.wr_reg) begin
                unique case (i_reg_addr) inside
                    REG_TONE_A_LO, REG_TONE_B_LO, REG_TONE_C_LO:
                        r_tone_period[i_reg_addr[2:1]][7:0] <= i_reg_value;
                    REG_TONE_A_HI, REG_TONE_B_HI, REG_TONE_C_HI:
                        r_tone_period[i_reg_addr[2:1]][11:8] <= i_reg_value[3:0];
                    REG_NOISE: r_noise_period <= i_reg_value[4:0];
                    REG_MIXER: r_mixer <= i_reg_value[5:0];
                    REG_VOL_A, REG_VOL_B, REG_VOL_C:
                        r_tone_vol[i_reg_addr[1:0]] <= i_reg_value[3:0];
                    default: ;
                endcase
            end
            if (i_cmd.commit) begin
                unique case (i_cmd.job)
                    JOB_RATE: begin
                        if (frac_sum >= {1'b0, rate}) begin
                            r_frac   <= 18'(frac_sum - {1'b0, rate});
                            r_cycles <= div_quot[22:0] + 23'd1;
                        end else begin
                            r_frac   <= frac_sum[17:0];
                            r_cycles <= div_quot[22:0];
                        end
                    end
                    JOB_NOISE: begin
                        r_noise_count <= div_rem[7:0];
                        r_shifts      <= fold[LFSR_W-1:0];
                    end
                    default: begin
                        r_tone_level[job_ch] <= r_tone_level[job_ch] ^ div_quot[0];
                        r_tone_count[job_ch] <= div_rem[14:0];
                    end
                endcase
            end
            if (i_cmd.jump && r_shifts[i_cmd.jump_bit]) begin
                r_noise <= n_noise_jmp;
            end
            if (i_cmd.filt) begin
                r_hp      <= 16'(y_clamp);
                r_hp_prev <= r_x;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mix) begin
            r_x <= {1'b0, mix} + {mix, 1'b0};
        end
        if (i_cmd.filt) begin
            r_out_sample <= 16'(y_clamp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.filt) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign i_cfg.ready     = i_rst_n;
    assign o_res.valid     = r_out_valid;
    assign o_res.sample    = r_out_sample;
    assign o_stat.div_done = div_done;
    assign o_stat.out_free = !r_out_valid || o_res.ready;

endmodule

// ===== rtl/psg_ctrl.sv =====
// Controller: sequences register writes and the steps of one sample tick.
`include "psg_tone_noise_mixer_assert.svh"

module psg_ctrl
    import psg_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  logic     i_cmd,
    output logic     o_ready,
    output t_dp_cmd  o_dp,
    input  t_dp_stat i_dp
);

    t_state     r_state;
    t_state     n_state;
    t_job       r_job;
    t_job       n_job;
    logic [4:0] r_bit;
    logic [4:0] n_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_job   <= JOB_RATE;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_job   <= n_job;
            r_bit   <= n_bit;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_job    = r_job;
        n_bit    = r_bit;
        o_ready  = 1'b0;
        o_dp     = '0;
        o_dp.job = r_job;
        o_dp.jump_bit = r_bit;
        unique case (r_state)
            S_IDLE: begin
                // take no request while reset is held
                o_ready = i_rst_n;
                if (i_valid) begin
                    if (i_cmd == CMD_TICK) begin
                        n_job   = JOB_RATE;
                        n_state = S_LAUNCH;
                    end else begin
                        o_dp.wr_reg = 1'b1;
                    end
                end
            end
            S_LAUNCH: begin
                o_dp.div_start = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                if (i_dp.div_done) begin
                    o_dp.commit = 1'b1;
                    // advance to the next division, or hand over to the noise jump
                    unique case (r_job)
                        JOB_RATE:   n_job = JOB_TONE_A;
                        JOB_TONE_A: n_job = JOB_TONE_B;
                        JOB_TONE_B: n_job = JOB_TONE_C;
                        JOB_TONE_C: n_job = JOB_NOISE;
                        default:    n_job = r_job;
                    endcase
                    if (r_job == JOB_NOISE) begin
                        n_bit   = '0;
                        n_state = S_JUMP;
                    end else begin
                        n_state = S_LAUNCH;
                    end
                end
            end
            S_JUMP: begin
                o_dp.jump = 1'b1;
                if (r_bit == JUMP_LAST) begin
                    n_state = S_MIX;
                end else begin
                    n_bit = r_bit + 5'd1;
                end
            end
            S_MIX: begin
                o_dp.mix = 1'b1;
                n_state  = S_FILT;
            end
            S_FILT: begin
                // hold until the result register is free
                if (i_dp.out_free) begin
                    o_dp.filt = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    `PSG_ASSERT_NEXT(a_tick_starts_rate, i_clk, i_rst_n, o_ready && i_valid && i_cmd == CMD_TICK, r_state == S_LAUNCH && r_job == JOB_RATE, "tick did not start with the rate division")
    `PSG_ASSERT_IMPLY(a_done_in_div, i_clk, i_rst_n, i_dp.div_done, r_state == S_DIV, "divider finished outside a division step")
    `PSG_ASSERT_NEXT(a_start_not_done, i_clk, i_rst_n, o_dp.div_start, !i_dp.div_done, "divider finished one cycle after start")
    `PSG_ASSERT_NEXT(a_noise_to_jump, i_clk, i_rst_n, o_dp.commit && o_dp.job == JOB_NOISE, r_state == S_JUMP && r_bit == 5'd0, "noise commit not followed by jump from bit zero")

endmodule

// ===== rtl/psg_tone_noise_mixer.sv =====
// Top level of the three-channel tone and noise sound generator.
// A register write request (cmd 0) is taken straight from the idle state. A
// sample tick request (cmd 1) produces one 16-bit sample; no further request
// is taken until the tick is back in idle. The shared divider, which handles
// two quotient bits a cycle, is used five times per tick (clock over sample
// rate, three tone spans, the noise span), followed by a 17-step jump of the
// noise register, a mixing step and a filtering step. A finished sample waits
// in the result register while the next request is taken; a tick only stalls
// at its filter step if that sample has still not been collected. The
// configuration port is ready whenever reset is released; write it only while
// no tick is in flight.
module psg_tone_noise_mixer
    import psg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    psg_in_if.sink    i_req,
    psg_cfg_if.sink   i_cfg,
    psg_out_if.source o_res
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    psg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .i_cmd   (i_req.cmd),
        .o_ready (i_req.ready),
        .o_dp    (dp_cmd),
        .i_dp    (dp_stat)
    );

    psg_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_reg_addr  (i_req.reg_addr),
        .i_reg_value (i_req.reg_value),
        .i_cfg       (i_cfg),
        .o_res       (o_res)
    );

endmodule

// ===== tb/psg_tone_noise_mixer_tb.sv =====
// Self-checking testbench for the tone and noise sound generator with its own sample predictor.
module psg_tone_noise_mixer_tb;
    import psg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_PHASES    = 7;
    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE      = 120;

    localparam logic [3:0] REG_UNUSED_LO = REG_VOL_C + 4'd1;
    localparam logic [3:0] REG_UNUSED_HI = 4'hf;

    localparam int unsigned VOL_STEP [16] = '{
        0, 23, 33, 47, 67, 95, 135, 191, 270, 382, 541, 766, 1084, 1534, 2171, 3072
    };

    typedef struct packed {
        logic       cmd;
        logic [3:0] addr;
        logic [7:0] value;
    } t_sound_req;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_SPARSE,
        SINK_BLOCKS
    } t_sink_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    psg_in_if  req_bus ();
    psg_cfg_if cfg_bus ();
    psg_out_if res_bus ();

    psg_tone_noise_mixer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .i_cfg   (cfg_bus),
        .o_res   (res_bus)
    );

    always #5 i_clk = ~i_clk;

    // generator state as the block should hold it
    int unsigned gen_clock = 32'(CHIP_CLOCK_RST);
    int unsigned gen_rate  = 32'(SAMPLE_RATE_RST);
    logic [11:0] gen_period [3] = '{12'd1, 12'd1, 12'd1};
    logic [3:0]  gen_vol [3]    = '{4'd0, 4'd0, 4'd0};
    int unsigned gen_count [3]  = '{0, 0, 0};
    logic        gen_level [3]  = '{1'b0, 1'b0, 1'b0};
    logic [4:0]  gen_noise_period = 5'd1;
    int unsigned gen_noise_count  = 0;
    logic [16:0] gen_lfsr  = 17'd1;
    logic [5:0]  gen_mixer = 6'h3f;
    int unsigned gen_frac  = 0;
    int          gen_hp_out  = 0;
    int          gen_hp_prev = 0;

    t_sound_req        req_queue [$];
    logic signed [15:0] sample_queue [$];
    t_sound_req        on_bus;

    int req_pushed      = 0;
    int req_accepted    = 0;
    int ticks_predicted = 0;
    int samples_checked = 0;
    int fail_count      = 0;
    int burst_left;
    int gap_left;
    int stall_cycles    = 0;

    task automatic push_req(input logic cmd, input logic [3:0] addr, input logic [7:0] value);
        t_sound_req r;
        r.cmd   = cmd;
        r.addr  = addr;
        r.value = value;
        req_queue.push_back(r);
        req_pushed++;
    endtask

    // Apply one accepted request to the generator state; a tick yields the next sample.
    task automatic compute_sample(input t_sound_req r);
        int unsigned rate;
        int unsigned cycles;
        int unsigned span;
        int unsigned total;
        int unsigned hops;
        int unsigned mix;
        int          x;
        int          y;
        int          ch;
        logic        tone_off;
        logic        noise_off;
        if (r.cmd == CMD_WRITE) begin
            case (r.addr)
                REG_TONE_A_LO, REG_TONE_B_LO, REG_TONE_C_LO: begin
                    gen_period[r.addr[2:1]][7:0] = r.value;
                end
                REG_TONE_A_HI, REG_TONE_B_HI, REG_TONE_C_HI: begin
                    gen_period[r.addr[2:1]][11:8] = r.value[3:0];
                end
                REG_NOISE: gen_noise_period = r.value[4:0];
                REG_MIXER: gen_mixer = r.value[5:0];
                REG_VOL_A, REG_VOL_B, REG_VOL_C: begin
                    gen_vol[2'(r.addr - REG_VOL_A)] = r.value[3:0];
                end
                default: ;
            endcase
            return;
        end

        rate = (gen_rate == 0) ? 1 : gen_rate;
        cycles = gen_clock / rate;
        // carry the remainder, folding it back at most once per tick
        gen_frac = gen_frac + gen_clock % rate;
        if (gen_frac >= rate) begin
            gen_frac = gen_frac - rate;
            cycles++;
        end
        gen_frac = gen_frac & 32'h3ffff;

        for (ch = 0; ch < 3; ch++) begin
            span = 8 * ((gen_period[ch] == '0) ? 32'd1 : 32'(gen_period[ch]));
            total = gen_count[ch] + cycles;
            hops = total / span;
            gen_level[ch] = gen_level[ch] ^ hops[0];
            gen_count[ch] = total % span;
        end

        span = 8 * ((gen_noise_period == '0) ? 32'd1 : 32'(gen_noise_period));
        total = gen_noise_count + cycles;
        hops = (total / span) % 32'(NOISE_CYCLE);
        gen_noise_count = total % span;
        repeat (hops) gen_lfsr = {gen_lfsr[0] ^ gen_lfsr[3], gen_lfsr[16:1]};

        mix = 0;
        for (ch = 0; ch < 3; ch++) begin
            tone_off  = gen_mixer[ch];
            noise_off = gen_mixer[ch + 3];
            if ((!tone_off || !noise_off) && (tone_off || gen_level[ch]) &&
                (noise_off || gen_lfsr[0])) begin
                mix = mix + VOL_STEP[gen_vol[ch]];
            end
        end

        x = int'(mix * 3);
        y = x - gen_hp_prev + (gen_hp_out * 1023) / 1024;
        gen_hp_prev = x;
        if (y > CLAMP_HI) y = CLAMP_HI;
        if (y < CLAMP_LO) y = CLAMP_LO;
        gen_hp_out = y;
        sample_queue.push_back(y[15:0]);
        ticks_predicted++;
    endtask

    // request driver: bursts of random length separated by random gaps
    always @(posedge i_clk) begin : driver
        logic hold;
        if (!i_rst_n) begin
            req_bus.valid     <= 1'b0;
            req_bus.cmd       <= CMD_WRITE;
            req_bus.reg_addr  <= '0;
            req_bus.reg_value <= '0;
            burst_left = $urandom_range(1, 24);
            gap_left   = 0;
        end else begin
            hold = req_bus.valid;
            if (req_bus.valid && req_bus.ready) begin
                compute_sample(on_bus);
                req_accepted++;
                hold = 1'b0;
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    if ($urandom_range(9) < 4) gap_left = 0;
                    else if ($urandom_range(9) == 0) gap_left = $urandom_range(20, 60);
                    else gap_left = $urandom_range(1, 8);
                end
            end
            if (!hold) begin
                if (gap_left > 0) begin
                    gap_left--;
                    req_bus.valid <= 1'b0;
                end else if (req_queue.size() > 0) begin
                    on_bus = req_queue.pop_front();
                    req_bus.valid     <= 1'b1;
                    req_bus.cmd       <= on_bus.cmd;
                    req_bus.reg_addr  <= on_bus.addr;
                    req_bus.reg_value <= on_bus.value;
                end else begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // result sink: switches between open, sparse and blocky stall patterns
    always @(posedge i_clk) begin : sink
        static t_sink_mode mode = SINK_OPEN;
        static int mode_left = 200;
        static int run_left  = 0;
        static logic level   = 1'b1;
        if (!i_rst_n) begin
            res_bus.ready <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                mode = t_sink_mode'($urandom_range(2));
                mode_left = $urandom_range(50, 400);
            end else begin
                mode_left--;
            end
            case (mode)
                SINK_OPEN: res_bus.ready <= 1'b1;
                SINK_SPARSE: res_bus.ready <= ($urandom_range(3) != 0);
                default: begin
                    if (run_left == 0) begin
                        level = !level;
                        run_left = level ? $urandom_range(1, 10) : $urandom_range(1, 40);
                    end else begin
                        run_left--;
                    end
                    res_bus.ready <= level;
                end
            endcase
        end
    end

    always @(posedge i_clk) begin : monitor
        logic signed [15:0] want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (sample_queue.size() == 0) begin
                $error("sample %0d delivered with none expected", res_bus.sample);
                fail_count++;
            end else begin
                want = sample_queue.pop_front();
                samples_checked++;
                if (res_bus.sample !== want) begin
                    $error("sample mismatch: expected %0d, actual %0d", want, res_bus.sample);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        int phase;
        int unsigned clock_hz;
        int unsigned rate_hz;
        int start;
        int ch;
        i_rst_n = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = CFG_CHIP_CLOCK;
        cfg_bus.data  = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (phase = 0; phase < N_PHASES; phase++) begin
            if (phase > 0) begin
                case (phase)
                    1: begin clock_hz = 100000;  rate_hz = 192000; end
                    2: begin clock_hz = 4000000; rate_hz = 8000;   end
                    3: begin clock_hz = 4000000; rate_hz = 0;      end
                    default: begin
                        clock_hz = $urandom_range(4000000, 100000);
                        rate_hz  = $urandom_range(192000, 8000);
                    end
                endcase
                // hold valid across both writes
                cfg_bus.valid <= 1'b1;
                cfg_bus.index <= CFG_CHIP_CLOCK;
                cfg_bus.data  <= 22'(clock_hz);
                do @(posedge i_clk); while (!cfg_bus.ready);
                gen_clock = clock_hz & 32'h3fffff;
                cfg_bus.index <= CFG_SAMPLE_RATE;
                cfg_bus.data  <= 22'(rate_hz);
                do @(posedge i_clk); while (!cfg_bus.ready);
                gen_rate = rate_hz & 32'h3ffff;
                cfg_bus.valid <= 1'b0;
            end

            case (phase)
                0: begin
                    push_req(CMD_TICK, REG_TONE_A_LO, 8'h00);
                    push_req(CMD_WRITE, REG_VOL_A, 8'hff);
                    push_req(CMD_WRITE, REG_VOL_B, 8'h0f);
                    push_req(CMD_WRITE, REG_VOL_C, 8'hf7);
                    push_req(CMD_WRITE, REG_TONE_A_LO, 8'hff);
                    push_req(CMD_WRITE, REG_TONE_A_HI, 8'hff);
                    push_req(CMD_WRITE, REG_TONE_B_LO, 8'h00);
                    push_req(CMD_WRITE, REG_TONE_B_HI, 8'h00);
                    push_req(CMD_WRITE, REG_TONE_C_LO, 8'h01);
                    push_req(CMD_WRITE, REG_TONE_C_HI, 8'hf0);
                    push_req(CMD_WRITE, REG_NOISE, 8'h00);
                    push_req(CMD_WRITE, REG_MIXER, 8'h00);
                    push_req(CMD_TICK, 4'hf, 8'hff);
                    push_req(CMD_TICK, REG_TONE_A_LO, 8'h00);
                    push_req(CMD_WRITE, REG_NOISE, 8'hff);
                    push_req(CMD_WRITE, REG_MIXER, 8'h38);
                    push_req(CMD_TICK, REG_MIXER, 8'h5a);
                    push_req(CMD_WRITE, REG_MIXER, 8'hc7);
                    push_req(CMD_TICK, REG_VOL_A, 8'ha5);
                    push_req(CMD_WRITE, REG_UNUSED_LO, 8'hff);
                    push_req(CMD_WRITE, REG_UNUSED_HI, 8'haa);
                    push_req(CMD_TICK, REG_UNUSED_LO, 8'h00);
                    push_req(CMD_WRITE, REG_MIXER, 8'h00);
                    push_req(CMD_TICK, REG_UNUSED_HI, 8'hff);
                end
                3: begin
                    // zero rate: a whole chip second per tick, many noise shifts
                    push_req(CMD_WRITE, REG_MIXER, 8'h00);
                    push_req(CMD_WRITE, REG_VOL_A, 8'h0f);
                    push_req(CMD_WRITE, REG_NOISE, 8'h1f);
                    repeat (4) push_req(CMD_TICK, 4'($urandom), 8'($urandom));
                end
                default: begin
                    start = req_pushed;
                    while (req_pushed - start < 140) begin
                        if ($urandom_range(9) < 7) begin
                            // set up one voice, then let it play for a few ticks
                            ch = $urandom_range(2);
                            push_req(CMD_WRITE, REG_TONE_A_LO + 4'(2 * ch), 8'($urandom));
                            push_req(CMD_WRITE, REG_TONE_A_HI + 4'(2 * ch),
                                     $urandom_range(1) ? 8'($urandom) : 8'h00);
                            push_req(CMD_WRITE, REG_VOL_A + 4'(ch), 8'($urandom) | 8'h08);
                            if ($urandom_range(1))
                                push_req(CMD_WRITE, REG_MIXER, 8'($urandom));
                            if ($urandom_range(2) == 0)
                                push_req(CMD_WRITE, REG_NOISE, 8'($urandom));
                            repeat ($urandom_range(1, 6))
                                push_req(CMD_TICK, 4'($urandom), 8'($urandom));
                        end else if ($urandom_range(9) < 5) begin
                            push_req(CMD_TICK, 4'($urandom), 8'($urandom));
                        end else if ($urandom_range(9) < 8) begin
                            push_req(CMD_WRITE, 4'($urandom_range(REG_VOL_C)), 8'($urandom));
                        end else begin
                            push_req(CMD_WRITE, 4'($urandom_range(REG_UNUSED_HI, REG_UNUSED_LO)),
                                     8'($urandom));
                        end
                    end
                end
            endcase

            // drain, then let any trailing write settle before touching the rates
            while (req_accepted != req_pushed || sample_queue.size() != 0) @(posedge i_clk);
            repeat (SETTLE) @(posedge i_clk);
        end

        $display("ran %0d requests (%0d ticks) over %0d rate settings with gaps and stalls",
                 req_accepted, ticks_predicted, N_PHASES);
        $display("compared %0d samples, %0d failures", samples_checked, fail_count);
        if (fail_count == 0 && sample_queue.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
